// ===== sv/vnf_pkg.sv =====
// Shared constants, types and constant functions for the value noise fBm generator.
// No dependencies; the other files that use this package refer to it by scoped names.
package vnf_pkg;

    localparam int MAX_OCTAVES_DEF = 4;

    localparam int LANE_STAGES = 12;
    localparam int TERM_W      = 42;
    localparam int AMP_W       = 17;
    localparam int NORM_W      = 18;
    localparam int DIVISOR_W   = NORM_W + 8;
    localparam int QUO_W       = 17;
    localparam int NOISE_W     = 18;
    localparam int PADDR_W     = 4;

    localparam logic [31:0] HASH_MX = 32'h8DA6B343;
    localparam logic [31:0] HASH_MZ = 32'hD8163841;
    localparam logic [31:0] HASH_M3 = 32'h2C1B3C6D;
    localparam logic [31:0] HASH_M4 = 32'h297A2D39;

    localparam logic [31:0] SALT_STEP_FBM = 32'h00009E37;
    localparam logic [31:0] SALT_STEP_RDG = 32'h000051ED;

    localparam logic [63:0] OFS_FBM_X = 64'h000000114F5C28F6;
    localparam logic [63:0] OFS_FBM_Z = 64'h00000009C51EB852;
    localparam logic [63:0] OFS_RDG_X = 64'h000000052147AE14;
    localparam logic [63:0] OFS_RDG_Z = 64'h0000000BE6666666;

    localparam logic [17:0] FREQ_RDG_Q16 = 18'd134349;
    localparam logic [15:0] AMP_RDG_Q16  = 16'd36045;

    localparam logic [31:0] INV_WAVELENGTH_RST = 32'd65536;
    localparam logic [2:0]  OCTAVE_COUNT_RST   = 3'd4;

    typedef enum logic [1:0] {
        REG_BASE_SALT,
        REG_INV_WAVELENGTH,
        REG_OCTAVE_COUNT,
        REG_NOISE_MODE
    } cfg_reg_t;

    typedef struct packed {
        logic        ridged;
        logic [31:0] base_salt;
    } octave_cfg_t;

    function automatic logic [AMP_W-1:0] amp_of(input logic ridged, input int oct);
        logic [AMP_W-1:0] af;
        logic [AMP_W-1:0] ar;
        af = AMP_W'(65536);
        ar = AMP_W'(65536);
        for (int i = 0; i < 8; i++)
        begin
            if (i < oct)
            begin
                af = af >> 1;
                ar = AMP_W'((34'(ar) * 34'(AMP_RDG_Q16)) >> 16);
            end
        end
        return ridged ? ar : af;
    endfunction

    function automatic logic [NORM_W-1:0] norm_of(input logic ridged, input logic [3:0] oct);
        logic [NORM_W-1:0] acc;
        logic [AMP_W-1:0]  af;
        logic [AMP_W-1:0]  ar;
        acc = '0;
        af  = AMP_W'(65536);
        ar  = AMP_W'(65536);
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < oct)
            begin
                acc = acc + NORM_W'(ridged ? ar : af);
            end
            af = af >> 1;
            ar = AMP_W'((34'(ar) * 34'(AMP_RDG_Q16)) >> 16);
        end
        return acc;
    endfunction

endpackage

// ===== sv/vnf_in_if.sv =====
// Sample request channel: signed world coordinate pair with valid/ready.
// Depends on nothing.
interface vnf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_coord;
    logic signed [31:0] z_coord;

    modport source (output valid, output x_coord, output z_coord, input ready);
    modport sink   (input valid, input x_coord, input z_coord, output ready);
endinterface

// ===== sv/vnf_out_if.sv =====
// Noise result channel: signed Q1.16 noise value with valid/ready.
// Depends on vnf_pkg for the field width.
interface vnf_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [vnf_pkg::NOISE_W-1:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

// ===== sv/vnf_octave.sv =====
// One octave lane: lattice scaling, four corner hashes, smoothstep blend, weighted term.
// Depends on vnf_pkg; stage enables come from the top-level pipeline control.
module vnf_octave #(
    parameter int OCT_IDX = 0,
    parameter int FREQ_W  = 32 + vnf_pkg::MAX_OCTAVES_DEF
) (
    input  logic                               clk,
    input  logic [vnf_pkg::LANE_STAGES-1:0]    en,
    input  logic signed [31:0]                 x_coord,
    input  logic signed [31:0]                 z_coord,
    input  logic [FREQ_W-1:0]                  freq,
    input  vnf_pkg::octave_cfg_t               cfg,
    output logic signed [vnf_pkg::TERM_W-1:0]  term
);

    localparam logic [63:0] OX_F = 64'(OCT_IDX) * vnf_pkg::OFS_FBM_X;
    localparam logic [63:0] OX_R = 64'd0 - 64'(OCT_IDX) * vnf_pkg::OFS_RDG_X;
    localparam logic [63:0] OZ_F = 64'd0 - 64'(OCT_IDX) * vnf_pkg::OFS_FBM_Z;
    localparam logic [63:0] OZ_R = 64'(OCT_IDX) * vnf_pkg::OFS_RDG_Z;
    localparam logic [31:0] SALT_F = 32'(OCT_IDX) * vnf_pkg::SALT_STEP_FBM;
    localparam logic [31:0] SALT_R = 32'(OCT_IDX) * vnf_pkg::SALT_STEP_RDG;
    localparam logic [vnf_pkg::AMP_W-1:0] AMP_F = vnf_pkg::amp_of(1'b0, OCT_IDX);
    localparam logic [vnf_pkg::AMP_W-1:0] AMP_R = vnf_pkg::amp_of(1'b1, OCT_IDX);
    localparam int TW = vnf_pkg::TERM_W;

    function automatic logic [23:0] blend(input logic [23:0] p, input logic [23:0] q,
                                          input logic [16:0] w);
        logic [40:0] s;
        s = 41'(p) * 41'(17'h10000 - w) + 41'(q) * 41'(w);
        return s[39:16];
    endfunction

    logic [31:0] xu;
    logic [31:0] zu;
    logic [31:0] fhi32;
    logic [31:0] salt;
    logic [63:0] lx;
    logic [63:0] lz;
    logic [31:0] mx1;
    logic [31:0] mz1;
    logic [31:0] hs [4];
    logic [31:0] h1_next [4];
    logic [31:0] t6 [4];
    logic [31:0] t7 [4];
    logic [49:0] psx;
    logic [49:0] psz;
    logic signed [24:0] n_c;
    logic [24:0] nabs;
    logic [49:0] pm;
    logic signed [TW-1:0] term_next;

    logic [63:0] plo_x_reg;
    logic [63:0] plo_z_reg;
    logic [31:0] phi_x_reg;
    logic [31:0] phi_z_reg;
    logic [31:0] ix_reg;
    logic [31:0] iz_reg;
    logic [15:0] tx_reg;
    logic [15:0] tz_reg;
    logic [31:0] mx_reg;
    logic [31:0] mz_reg;
    logic [31:0] tsq_x_reg;
    logic [31:0] tsq_z_reg;
    logic [17:0] k_x_reg;
    logic [17:0] k_z_reg;
    logic [31:0] h1_reg [4];
    logic [31:0] h2_reg [4];
    logic [31:0] h3_reg [4];
    logic [23:0] c_reg [4];
    logic [16:0] wx4_reg;
    logic [16:0] wz4_reg;
    logic [16:0] wx5_reg;
    logic [16:0] wz5_reg;
    logic [16:0] wx6_reg;
    logic [16:0] wz6_reg;
    logic [16:0] wx7_reg;
    logic [16:0] wz7_reg;
    logic [16:0] wz8_reg;
    logic [23:0] bx0_reg;
    logic [23:0] bx1_reg;
    logic [23:0] v_reg;
    logic signed [24:0] n_reg;
    logic [24:0] m_reg;
    logic signed [24:0] n11_reg;
    logic [24:0] sq_reg;
    logic signed [TW-1:0] term_reg;

    always_comb
    begin
        xu    = x_coord;
        zu    = z_coord;
        fhi32 = 32'(freq[FREQ_W-1:32]);
        salt  = cfg.base_salt + (cfg.ridged ? SALT_R : SALT_F);
        lx    = plo_x_reg + {phi_x_reg, 32'd0} + (cfg.ridged ? OX_R : OX_F);
        lz    = plo_z_reg + {phi_z_reg, 32'd0} + (cfg.ridged ? OZ_R : OZ_F);
        mx1   = mx_reg + vnf_pkg::HASH_MX;
        mz1   = mz_reg + vnf_pkg::HASH_MZ;
        hs[0] = salt ^ mx_reg ^ mz_reg;
        hs[1] = salt ^ mx1 ^ mz_reg;
        hs[2] = salt ^ mx_reg ^ mz1;
        hs[3] = salt ^ mx1 ^ mz1;
        for (int i = 0; i < 4; i++)
        begin
            h1_next[i] = hs[i] ^ (hs[i] >> 15);
            t6[i]      = h2_reg[i] ^ (h2_reg[i] >> 12);
            t7[i]      = h3_reg[i] ^ (h3_reg[i] >> 15);
        end
        psx  = 50'(tsq_x_reg) * 50'(k_x_reg);
        psz  = 50'(tsq_z_reg) * 50'(k_z_reg);
        // 2v - 1.0 in Q1.24 is 2v with the top bit flipped
        n_c  = $signed({~v_reg[23], v_reg[22:0], 1'b0});
        nabs = n_c[24] ? 25'(-n_c) : 25'(n_c);
        pm   = 50'(m_reg) * 50'(m_reg);
        if (cfg.ridged)
        begin
            term_next = $signed(TW'(sq_reg)) * $signed(TW'(AMP_R));
        end
        else
        begin
            term_next = TW'(n11_reg) * $signed(TW'(AMP_F));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            plo_x_reg <= 64'(xu) * 64'(freq[31:0]);
            plo_z_reg <= 64'(zu) * 64'(freq[31:0]);
            phi_x_reg <= xu * fhi32 - (xu[31] ? freq[31:0] : 32'd0);
            phi_z_reg <= zu * fhi32 - (zu[31] ? freq[31:0] : 32'd0);
        end
        if (en[1])
        begin
            ix_reg <= lx[63:32];
            iz_reg <= lz[63:32];
            tx_reg <= lx[31:16];
            tz_reg <= lz[31:16];
        end
        if (en[2])
        begin
            mx_reg    <= ix_reg * vnf_pkg::HASH_MX;
            mz_reg    <= iz_reg * vnf_pkg::HASH_MZ;
            tsq_x_reg <= 32'(tx_reg) * 32'(tx_reg);
            tsq_z_reg <= 32'(tz_reg) * 32'(tz_reg);
            k_x_reg   <= 18'd196608 - 18'({tx_reg, 1'b0});
            k_z_reg   <= 18'd196608 - 18'({tz_reg, 1'b0});
        end
        if (en[3])
        begin
            h1_reg  <= h1_next;
            wx4_reg <= psx[48:32];
            wz4_reg <= psz[48:32];
        end
        if (en[4])
        begin
            for (int i = 0; i < 4; i++)
            begin
                h2_reg[i] <= h1_reg[i] * vnf_pkg::HASH_M3;
            end
            wx5_reg <= wx4_reg;
            wz5_reg <= wz4_reg;
        end
        if (en[5])
        begin
            for (int i = 0; i < 4; i++)
            begin
                h3_reg[i] <= t6[i] * vnf_pkg::HASH_M4;
            end
            wx6_reg <= wx5_reg;
            wz6_reg <= wz5_reg;
        end
        if (en[6])
        begin
            for (int i = 0; i < 4; i++)
            begin
                c_reg[i] <= t7[i][31:8];
            end
            wx7_reg <= wx6_reg;
            wz7_reg <= wz6_reg;
        end
        if (en[7])
        begin
            bx0_reg <= blend(c_reg[0], c_reg[1], wx7_reg);
            bx1_reg <= blend(c_reg[2], c_reg[3], wx7_reg);
            wz8_reg <= wz7_reg;
        end
        if (en[8])
        begin
            v_reg <= blend(bx0_reg, bx1_reg, wz8_reg);
        end
        if (en[9])
        begin
            n_reg <= n_c;
            m_reg <= 25'h1000000 - nabs;
        end
        if (en[10])
        begin
            n11_reg <= n_reg;
            sq_reg  <= pm[48:24];
        end
        if (en[11])
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

// ===== sv/vnf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for the final normalization.
// Depends on vnf_pkg; stage enables come from the top-level pipeline control.
module vnf_div #(
    parameter int R_W = 45
) (
    input  logic                              clk,
    input  logic [vnf_pkg::QUO_W-1:0]         en,
    input  logic [R_W-1:0]                    mag,
    input  logic                              neg_in,
    input  logic [vnf_pkg::DIVISOR_W-1:0]     divisor,
    output logic [vnf_pkg::QUO_W-1:0]         quo,
    output logic                              neg_out
);

    localparam int QW = vnf_pkg::QUO_W;

    logic [R_W-1:0] rem_reg [QW];
    logic [QW-1:0]  q_reg [QW];
    logic [QW-1:0]  neg_reg;

    for (genvar j = 0; j < QW; j++)
    begin : g_step
        localparam int BIT = QW - 1 - j;
        logic [R_W-1:0] rem_in;
        logic [QW-1:0]  q_in;
        logic           n_in;
        logic [R_W-1:0] dsh;
        logic           ge;

        if (j == 0)
        begin : g_first
            assign rem_in = mag;
            assign q_in   = '0;
            assign n_in   = neg_in;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign n_in   = neg_reg[j-1];
        end

        assign dsh = R_W'(divisor) << BIT;
        assign ge  = rem_in >= dsh;

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= ge ? rem_in - dsh : rem_in;
                q_reg[j]   <= q_in | (QW'(ge) << BIT);
                neg_reg[j] <= n_in;
            end
        end
    end

    assign quo     = q_reg[QW-1];
    assign neg_out = neg_reg[QW-1];

endmodule

// ===== sv/value_noise_fbm_generator.sv =====
// Value noise fBm / ridged multifractal generator, top level: APB registers, octave lanes,
// octave sum, normalizing divider. Depends on vnf_pkg, vnf_in_if, vnf_out_if, vnf_octave, vnf_div.
//
//  channel     dir   handshake           payload
//  sample_in   in    valid/ready         x_coord, z_coord (s32)
//  noise_out   out   valid/ready         noise_value (s18, Q1.16)
//  apb         in    psel/penable/pready paddr[3:0], pwdata/prdata (32)
//
// One request per clock while the frequency table is not rebuilding and noise_out is not stalled.
// Each config write rebuilds the octave frequency table: sample_in.ready stays low
// while it rebuilds (one step per octave after the first).
// Reset restores register defaults and empties the pipeline.
// Output stall backs up stage by stage; empty stages still fill, nothing is lost.
module value_noise_fbm_generator #(
    parameter int MAX_OCTAVES = vnf_pkg::MAX_OCTAVES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vnf_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    vnf_in_if.sink                        sample_in,
    vnf_out_if.source                     noise_out
);

    localparam int LS     = vnf_pkg::LANE_STAGES;
    localparam int QW     = vnf_pkg::QUO_W;
    localparam int N_ST   = LS + 2 + QW + 1;
    localparam int FREQ_W = 32 + MAX_OCTAVES;
    localparam int PROD_W = FREQ_W + 18;
    localparam int SUM_W  = vnf_pkg::TERM_W + $clog2(MAX_OCTAVES) + 1;
    localparam int SEQ_W  = $clog2(MAX_OCTAVES + 1);
    localparam int NW     = vnf_pkg::NOISE_W;

    // configuration
    logic [31:0] base_salt_reg;
    logic [31:0] inv_wavelength_reg;
    logic [2:0]  octave_count_reg;
    logic        noise_mode_reg;
    logic        wr;
    vnf_pkg::cfg_reg_t widx;
    logic [31:0] inv_next;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign widx   = vnf_pkg::cfg_reg_t'(paddr[3:2]);
    assign inv_next = (wr && widx == vnf_pkg::REG_INV_WAVELENGTH) ? pwdata : inv_wavelength_reg;

    always_comb
    begin
        case (vnf_pkg::cfg_reg_t'(paddr[3:2]))
            vnf_pkg::REG_BASE_SALT:      prdata = base_salt_reg;
            vnf_pkg::REG_INV_WAVELENGTH: prdata = inv_wavelength_reg;
            vnf_pkg::REG_OCTAVE_COUNT:   prdata = 32'(octave_count_reg);
            vnf_pkg::REG_NOISE_MODE:     prdata = 32'(noise_mode_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_salt_reg      <= '0;
            inv_wavelength_reg <= vnf_pkg::INV_WAVELENGTH_RST;
            octave_count_reg   <= vnf_pkg::OCTAVE_COUNT_RST;
            noise_mode_reg     <= 1'b0;
        end
        else if (wr)
        begin
            case (widx)
                vnf_pkg::REG_BASE_SALT:      base_salt_reg      <= pwdata;
                vnf_pkg::REG_INV_WAVELENGTH: inv_wavelength_reg <= pwdata;
                vnf_pkg::REG_OCTAVE_COUNT:   octave_count_reg   <= pwdata[2:0];
                vnf_pkg::REG_NOISE_MODE:     noise_mode_reg     <= pwdata[0];
                default:                     base_salt_reg      <= base_salt_reg;
            endcase
        end
    end

    // octave frequency table, rebuilt after every write
    logic              busy_reg;
    logic [SEQ_W-1:0]  seq_cnt_reg;
    logic [FREQ_W-1:0] cur_reg;
    logic [PROD_W-1:0] fprod;
    logic [FREQ_W-1:0] fstep;
    logic [FREQ_W-1:0] lane_freq [MAX_OCTAVES];

    assign fprod = PROD_W'(cur_reg) * PROD_W'(vnf_pkg::FREQ_RDG_Q16);
    assign fstep = noise_mode_reg ? fprod[FREQ_W+15:16] : (cur_reg << 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            seq_cnt_reg <= '0;
            cur_reg     <= FREQ_W'(vnf_pkg::INV_WAVELENGTH_RST);
        end
        else if (wr)
        begin
            busy_reg    <= 1'(MAX_OCTAVES > 1);
            seq_cnt_reg <= SEQ_W'(1);
            cur_reg     <= FREQ_W'(inv_next);
        end
        else if (busy_reg)
        begin
            cur_reg     <= fstep;
            seq_cnt_reg <= seq_cnt_reg + SEQ_W'(1);
            if (seq_cnt_reg == SEQ_W'(MAX_OCTAVES - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < MAX_OCTAVES; i++)
    begin : g_freq
        if (i == 0)
        begin : g_base
            assign lane_freq[i] = FREQ_W'(inv_wavelength_reg);
        end
        else
        begin : g_tab
            localparam logic [FREQ_W-1:0] FRST = FREQ_W'(vnf_pkg::INV_WAVELENGTH_RST) << i;
            logic [FREQ_W-1:0] freq_reg;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    freq_reg <= FRST;
                end
                else if (busy_reg && !wr && seq_cnt_reg == SEQ_W'(i))
                begin
                    freq_reg <= fstep;
                end
            end
            assign lane_freq[i] = freq_reg;
        end
    end

    // pipeline control
    logic [N_ST-1:0] v_reg;
    logic [N_ST-1:0] ld;
    logic            in_acc;

    always_comb
    begin
        ld[N_ST-1] = !v_reg[N_ST-1] || noise_out.ready;
        for (int k = N_ST - 2; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign sample_in.ready = ld[0] && !busy_reg;
    assign in_acc          = sample_in.valid && sample_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                v_reg[0] <= in_acc;
            end
            for (int k = 1; k < N_ST; k++)
            begin
                if (ld[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // octave lanes
    vnf_pkg::octave_cfg_t ocfg;
    logic signed [vnf_pkg::TERM_W-1:0] term [MAX_OCTAVES];
    logic [3:0] oct_eff;
    logic [MAX_OCTAVES-1:0] active;

    assign ocfg.ridged    = noise_mode_reg;
    assign ocfg.base_salt = base_salt_reg;

    always_comb
    begin
        if (octave_count_reg == 3'd0)
        begin
            oct_eff = 4'd1;
        end
        else if (4'(octave_count_reg) > 4'(MAX_OCTAVES))
        begin
            oct_eff = 4'(MAX_OCTAVES);
        end
        else
        begin
            oct_eff = 4'(octave_count_reg);
        end
        for (int o = 0; o < MAX_OCTAVES; o++)
        begin
            active[o] = 4'(o) < oct_eff;
        end
    end

    for (genvar o = 0; o < MAX_OCTAVES; o++)
    begin : g_lane
        vnf_octave #(
            .OCT_IDX (o),
            .FREQ_W  (FREQ_W)
        ) u_octave (
            .clk     (clk),
            .en      (ld[LS-1:0]),
            .x_coord (sample_in.x_coord),
            .z_coord (sample_in.z_coord),
            .freq    (lane_freq[o]),
            .cfg     (ocfg),
            .term    (term[o])
        );
    end

    // sum, sign split, divide by norm * 256
    logic signed [SUM_W-1:0] sum_c;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [vnf_pkg::DIVISOR_W-1:0] divisor;
    logic [QW-1:0]           quo;
    logic                    quo_neg;
    logic [NW-1:0]           noise_reg;

    always_comb
    begin
        sum_c = '0;
        for (int o = 0; o < MAX_OCTAVES; o++)
        begin
            if (active[o])
            begin
                sum_c = sum_c + SUM_W'(term[o]);
            end
        end
    end

    assign divisor = {vnf_pkg::norm_of(noise_mode_reg, oct_eff), 8'd0};

    always_ff @(posedge clk)
    begin
        if (ld[LS])
        begin
            sum_reg <= sum_c;
        end
        if (ld[LS+1])
        begin
            neg_reg <= sum_reg[SUM_W-1];
            mag_reg <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        end
        if (ld[N_ST-1])
        begin
            noise_reg <= quo_neg ? NW'(0) - NW'(quo) : NW'(quo);
        end
    end

    vnf_div #(
        .R_W (SUM_W)
    ) u_div (
        .clk     (clk),
        .en      (ld[LS+1+QW:LS+2]),
        .mag     (mag_reg),
        .neg_in  (neg_reg),
        .divisor (divisor),
        .quo     (quo),
        .neg_out (quo_neg)
    );

    assign noise_out.valid       = v_reg[N_ST-1];
    assign noise_out.noise_value = $signed(noise_reg);

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !sample_in.ready)
        else $error("request accepted while frequency table rebuilds");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> v_reg[0])
        else $error("accepted request missing from first stage");

    a_ridged_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (noise_out.valid && noise_mode_reg) |-> !noise_out.noise_value[NW-1])
        else $error("ridged result negative");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        noise_out.valid |-> (noise_out.noise_value <= 18'sd65536 &&
                             noise_out.noise_value >= -18'sd65536))
        else $error("noise value out of range");

endmodule

// ===== test/value_noise_fbm_generator_tb.sv =====
// Self-checking testbench for value_noise_fbm_generator: random and directed sample requests,
// APB register phases, an in-line noise predictor and an in-order result check.
// Depends on vnf_pkg, vnf_in_if, vnf_out_if and the generator RTL.
module value_noise_fbm_generator_tb;

    localparam int OCT_MAX   = vnf_pkg::MAX_OCTAVES_DEF;
    localparam int WD_LIMIT  = 20000;
    localparam int DRAIN_CYC = 60;

    typedef struct packed {
        logic signed [31:0] x_coord;
        logic signed [31:0] z_coord;
    } sample_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [vnf_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    vnf_in_if  sample_ch ();
    vnf_out_if noise_ch ();

    value_noise_fbm_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .sample_in (sample_ch.sink),
        .noise_out (noise_ch.source)
    );

    logic [31:0] cfg_salt;
    logic [31:0] cfg_inv_wl;
    logic [2:0]  cfg_octaves;
    logic        cfg_ridged;

    sample_t           sample_queue[$];
    logic [17:0]       noise_expected[$];
    int                errors;
    bit                no_idle;
    int                sink_hold;
    int                quiet_cycles;

    always #5 clk = ~clk;

    function automatic logic [31:0] lattice_mix(logic [31:0] ix, logic [31:0] iz,
                                                logic [31:0] salt);
        logic [31:0] h;
        h = salt;
        h = h ^ (ix * vnf_pkg::HASH_MX);
        h = h ^ (iz * vnf_pkg::HASH_MZ);
        h = h ^ (h >> 15);
        h = h * vnf_pkg::HASH_M3;
        h = h ^ (h >> 12);
        h = h * vnf_pkg::HASH_M4;
        h = h ^ (h >> 15);
        return h;
    endfunction

    function automatic logic [63:0] smooth_weight(logic [31:0] frac);
        logic [63:0] t;
        logic [63:0] k;
        t = 64'(frac[31:16]);
        k = (64'd3 << 16) - 2 * t;
        return (t * t * k) >> 32;
    endfunction

    function automatic logic [63:0] lerp16(logic [63:0] p, logic [63:0] q, logic [63:0] w);
        return (p * (64'd65536 - w) + q * w) >> 16;
    endfunction

    function automatic logic [63:0] octave_value(logic [63:0] lx, logic [63:0] lz,
                                                 logic [31:0] salt);
        logic [31:0] ix;
        logic [31:0] iz;
        logic [63:0] wx;
        logic [63:0] wz;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        ix = lx[63:32];
        iz = lz[63:32];
        wx = smooth_weight(lx[31:0]);
        wz = smooth_weight(lz[31:0]);
        a = 64'(lattice_mix(ix, iz, salt) >> 8);
        b = 64'(lattice_mix(ix + 32'd1, iz, salt) >> 8);
        c = 64'(lattice_mix(ix, iz + 32'd1, salt) >> 8);
        d = 64'(lattice_mix(ix + 32'd1, iz + 32'd1, salt) >> 8);
        return lerp16(lerp16(a, b, wx), lerp16(c, d, wx), wz);
    endfunction

    function automatic logic [17:0] predict_noise(sample_t s);
        logic [63:0] xs;
        logic [63:0] zs;
        logic [63:0] freq;
        logic [63:0] lx;
        logic [63:0] lz;
        logic [63:0] v;
        logic [63:0] m;
        logic [31:0] salt;
        longint      amp;
        longint      norm;
        longint      acc;
        longint      n;
        longint      r;
        int          oct;
        xs   = 64'(s.x_coord);
        zs   = 64'(s.z_coord);
        freq = 64'(cfg_inv_wl);
        amp  = 65536;
        norm = 0;
        acc  = 0;
        oct  = int'(cfg_octaves);
        if (oct == 0) oct = 1;
        if (oct > OCT_MAX) oct = OCT_MAX;
        for (int o = 0; o < oct; o++)
        begin
            if (!cfg_ridged)
            begin
                lx   = xs * freq + 64'(o) * vnf_pkg::OFS_FBM_X;
                lz   = zs * freq - 64'(o) * vnf_pkg::OFS_FBM_Z;
                salt = cfg_salt + 32'(o) * vnf_pkg::SALT_STEP_FBM;
            end
            else
            begin
                lx   = xs * freq - 64'(o) * vnf_pkg::OFS_RDG_X;
                lz   = zs * freq + 64'(o) * vnf_pkg::OFS_RDG_Z;
                salt = cfg_salt + 32'(o) * vnf_pkg::SALT_STEP_RDG;
            end
            v = octave_value(lx, lz, salt);
            n = 2 * longint'(v) - 64'sd16777216;
            if (!cfg_ridged)
            begin
                acc  = acc + n * amp;
                norm = norm + amp;
                amp  = amp / 2;
                freq = freq << 1;
            end
            else
            begin
                m    = 64'(64'sd16777216 - (n < 0 ? -n : n));
                acc  = acc + longint'((m * m) >> 24) * amp;
                norm = norm + amp;
                amp  = longint'((64'(amp) * 64'(vnf_pkg::AMP_RDG_Q16)) >> 16);
                freq = (freq * 64'(vnf_pkg::FREQ_RDG_Q16)) >> 16;
            end
        end
        r = acc / (norm * 256);
        return r[17:0];
    endfunction

    task automatic report_mismatch(string what, logic [17:0] got, logic [17:0] want);
        $display("noise_value %s: got %0d expected %0d at %0t",
                 what, $signed(got), $signed(want), $time);
        errors++;
    endtask

    // sender: offers queued requests, idles at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
                noise_expected.push_back(predict_noise({sample_ch.x_coord, sample_ch.z_coord}));
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (sample_queue.size() > 0 && (no_idle || $urandom_range(99) >= 30))
                begin
                    sample_t s;
                    s = sample_queue.pop_front();
                    sample_ch.valid   <= 1'b1;
                    sample_ch.x_coord <= s.x_coord;
                    sample_ch.z_coord <= s.z_coord;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: checks results in order, stalls at random or for a long hold
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (noise_ch.valid && noise_ch.ready)
            begin
                if (noise_expected.size() == 0)
                    report_mismatch("unexpected", noise_ch.noise_value, 18'd0);
                else
                begin
                    logic [17:0] want;
                    want = noise_expected.pop_front();
                    if (noise_ch.noise_value !== want)
                        report_mismatch("wrong", noise_ch.noise_value, want);
                end
            end
            if (sink_hold > 0)
            begin
                sink_hold      <= sink_hold - 1;
                noise_ch.ready <= 1'b0;
            end
            else
                noise_ch.ready <= no_idle || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (noise_ch.valid && noise_ch.ready)
            || (noise_expected.size() == 0 && sample_queue.size() == 0 && !sample_ch.valid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("value_noise_fbm_generator: mismatch");
            $finish;
        end
    end

    task automatic apb_write(vnf_pkg::cfg_reg_t idx, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= vnf_pkg::PADDR_W'(4 * int'(idx));
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            vnf_pkg::REG_BASE_SALT:      cfg_salt    = data;
            vnf_pkg::REG_INV_WAVELENGTH: cfg_inv_wl  = data;
            vnf_pkg::REG_OCTAVE_COUNT:   cfg_octaves = data[2:0];
            default:                     cfg_ridged  = data[0];
        endcase
    endtask

    task automatic set_config(logic [31:0] salt, logic [31:0] iw, logic [31:0] oct,
                              logic [31:0] mode);
        apb_write(vnf_pkg::REG_BASE_SALT, salt);
        apb_write(vnf_pkg::REG_INV_WAVELENGTH, iw);
        apb_write(vnf_pkg::REG_OCTAVE_COUNT, oct);
        apb_write(vnf_pkg::REG_NOISE_MODE, mode);
    endtask

    task automatic push_request(logic [31:0] x, logic [31:0] z);
        sample_queue.push_back({x, z});
    endtask

    task automatic wait_idle();
        while (sample_queue.size() > 0 || sample_ch.valid || noise_expected.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic push_directed();
        push_request(32'h0, 32'h0);
        push_request(32'h7FFFFFFF, 32'h7FFFFFFF);
        push_request(32'h80000000, 32'h80000000);
        push_request(32'h7FFFFFFF, 32'h80000000);
        push_request(32'hFFFFFFFF, 32'hFFFFFFFF);
        push_request(32'h1, 32'hFFFFFFFF);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom_range(2000) - 1000;
            1:       return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(3)
                                               : 32'h80000000 + $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_inv_wl();
        case ($urandom_range(5))
            0:       return 32'h0;
            1:       return 32'hFFFFFFFF;
            2:       return $urandom_range(1 << 20);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.x_coord = '0;
        sample_ch.z_coord = '0;
        noise_ch.ready = 1'b0;
        errors = 0;
        no_idle = 1'b0;
        sink_hold = 0;
        quiet_cycles = 0;
        cfg_salt = 32'h0;
        cfg_inv_wl = vnf_pkg::INV_WAVELENGTH_RST;
        cfg_octaves = vnf_pkg::OCTAVE_COUNT_RST;
        cfg_ridged = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // reset defaults
        push_directed();
        wait_idle();
        // zero octave count, zero inverse wavelength, ridged
        set_config(32'h0, 32'h0, 32'd0, 32'd1);
        push_directed();
        wait_idle();
        // octave count saturates, widest frequency and salt
        set_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd7, 32'd0);
        push_directed();
        wait_idle();
        set_config(32'h12345678, 32'hFFFFFFFF, 32'd1, 32'd1);
        push_directed();
        wait_idle();

        for (int ph = 0; ph < 11; ph++)
        begin
            set_config($urandom, rand_inv_wl(), $urandom_range(7), $urandom_range(1));
            no_idle = (ph == 3);
            for (int i = 0; i < 120; i++)
                push_request(rand_coord(), rand_coord());
            if (ph == 5)
                sink_hold = 400;
            wait_idle();
        end
        no_idle = 1'b0;

        if (errors == 0)
            $display("value_noise_fbm_generator: match");
        else
            $display("value_noise_fbm_generator: mismatch");
        $finish;
    end

endmodule
